// ----- rtl/aekd_pkg.sv -----
package aekd_pkg;

    localparam int MAX_SEQ_LEN = 16;
    localparam int LEN_W       = $clog2(MAX_SEQ_LEN + 1);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_CSI  = 2'd2,
        MODE_SS3  = 2'd3
    } mode_t;

    localparam logic [7:0] BYTE_ETX   = 8'd3;
    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_TAB   = 8'd9;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_ESC   = 8'd27;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_TILDE = 8'd126;
    localparam logic [7:0] BYTE_DEL   = 8'd127;
    localparam logic [7:0] BYTE_LBRK  = 8'd91;
    localparam logic [7:0] BYTE_SS3   = 8'd79;
    localparam logic [7:0] BYTE_UC_A  = 8'd65;
    localparam logic [7:0] BYTE_UC_Z  = 8'd90;

    localparam logic [4:0] KEY_UP        = 5'd0;
    localparam logic [4:0] KEY_DOWN      = 5'd1;
    localparam logic [4:0] KEY_RIGHT     = 5'd2;
    localparam logic [4:0] KEY_LEFT      = 5'd3;
    localparam logic [4:0] KEY_F1        = 5'd4;
    localparam logic [4:0] KEY_F2        = 5'd5;
    localparam logic [4:0] KEY_F3        = 5'd6;
    localparam logic [4:0] KEY_F4        = 5'd7;
    localparam logic [4:0] KEY_F5        = 5'd8;
    localparam logic [4:0] KEY_F6        = 5'd9;
    localparam logic [4:0] KEY_F7        = 5'd10;
    localparam logic [4:0] KEY_F8        = 5'd11;
    localparam logic [4:0] KEY_F9        = 5'd12;
    localparam logic [4:0] KEY_F10       = 5'd13;
    localparam logic [4:0] KEY_F11       = 5'd14;
    localparam logic [4:0] KEY_F12       = 5'd15;
    localparam logic [4:0] KEY_HOME      = 5'd16;
    localparam logic [4:0] KEY_END       = 5'd17;
    localparam logic [4:0] KEY_PGUP      = 5'd18;
    localparam logic [4:0] KEY_PGDN      = 5'd19;
    localparam logic [4:0] KEY_INS       = 5'd20;
    localparam logic [4:0] KEY_DELETE    = 5'd21;
    localparam logic [4:0] KEY_ENTER     = 5'd22;
    localparam logic [4:0] KEY_BACKSPACE = 5'd23;
    localparam logic [4:0] KEY_TAB       = 5'd24;
    localparam logic [4:0] KEY_ESCAPE    = 5'd25;

    typedef struct packed {
        logic       is_printable;
        logic [6:0] char_code;
        logic [4:0] special_key;
    } key_event_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] key;
    } match_t;

endpackage

// ----- rtl/aekd_rx_if.sv -----
interface aekd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/aekd_key_if.sv -----
interface aekd_key_if;
    logic       valid;
    logic       ready;
    logic       is_printable;
    logic [6:0] char_code;
    logic [4:0] special_key;

    modport source (output valid, output is_printable, output char_code,
                    output special_key, input ready);
    modport sink (input valid, input is_printable, input char_code,
                  input special_key, output ready);
endinterface

// ----- rtl/aekd_seq_match.sv -----
module aekd_seq_match (
    input  logic                     is_csi,
    input  logic [aekd_pkg::LEN_W-1:0] len,
    input  logic [7:0]               byte2,
    input  logic [7:0]               byte3,
    input  logic [7:0]               cur,
    output aekd_pkg::match_t         match
);

    // len is the buffered length before the final byte
    always_comb
    begin
        match = '0;
        if (len == aekd_pkg::LEN_W'(2))
        begin
            match.hit = 1'b1;
            if (is_csi)
            begin
                case (cur)
                    "A": match.key = aekd_pkg::KEY_UP;
                    "B": match.key = aekd_pkg::KEY_DOWN;
                    "C": match.key = aekd_pkg::KEY_RIGHT;
                    "D": match.key = aekd_pkg::KEY_LEFT;
                    default: match.hit = 1'b0;
                endcase
            end
            else
            begin
                case (cur)
                    "P": match.key = aekd_pkg::KEY_F1;
                    "Q": match.key = aekd_pkg::KEY_F2;
                    "R": match.key = aekd_pkg::KEY_F3;
                    "S": match.key = aekd_pkg::KEY_F4;
                    default: match.hit = 1'b0;
                endcase
            end
        end
        else if (is_csi && cur == aekd_pkg::BYTE_TILDE && len == aekd_pkg::LEN_W'(3))
        begin
            match.hit = 1'b1;
            case (byte2)
                "1": match.key = aekd_pkg::KEY_HOME;
                "4": match.key = aekd_pkg::KEY_END;
                "5": match.key = aekd_pkg::KEY_PGUP;
                "6": match.key = aekd_pkg::KEY_PGDN;
                "2": match.key = aekd_pkg::KEY_INS;
                "3": match.key = aekd_pkg::KEY_DELETE;
                default: match.hit = 1'b0;
            endcase
        end
        else if (is_csi && cur == aekd_pkg::BYTE_TILDE && len == aekd_pkg::LEN_W'(4))
        begin
            match.hit = 1'b1;
            case ({byte2, byte3})
                "15": match.key = aekd_pkg::KEY_F5;
                "17": match.key = aekd_pkg::KEY_F6;
                "18": match.key = aekd_pkg::KEY_F7;
                "19": match.key = aekd_pkg::KEY_F8;
                "20": match.key = aekd_pkg::KEY_F9;
                "21": match.key = aekd_pkg::KEY_F10;
                "23": match.key = aekd_pkg::KEY_F11;
                "24": match.key = aekd_pkg::KEY_F12;
                default: match.hit = 1'b0;
            endcase
        end
    end

endmodule

// ----- rtl/ansi_escape_key_decoder.sv -----
// a key event is registered and shows valid in the cycle after the byte's transaction
// one byte per cycle unless a held event stalls; output register refills as it drains
// the sequence compare sits between the parser state registers and the output register
// reset: parser returns to idle with an empty sequence, no event pending
module ansi_escape_key_decoder (
    input  logic              clk,
    input  logic              rst_n,
    aekd_rx_if.sink           rx,
    aekd_key_if.source        key
);

    localparam int LW = aekd_pkg::LEN_W;

    aekd_pkg::mode_t      mode_reg, mode_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [7:0]           byte2_reg, byte2_next;
    logic [7:0]           byte3_reg, byte3_next;
    logic                 out_valid_reg, out_valid_next;
    aekd_pkg::key_event_t out_reg, out_next;

    logic                 accept;
    logic                 emit;
    aekd_pkg::key_event_t event_val;
    aekd_pkg::match_t     match;
    logic                 is_final;
    logic [LW-1:0]        len_inc;
    logic [7:0]           b;

    assign b        = rx.rx_byte;
    assign rx.ready = !out_valid_reg || key.ready;
    assign accept   = rx.valid && rx.ready;
    assign is_final = (b >= aekd_pkg::BYTE_UC_A && b <= aekd_pkg::BYTE_UC_Z)
                      || b == aekd_pkg::BYTE_TILDE;
    assign len_inc  = len_reg + LW'(1);

    aekd_seq_match u_match (
        .is_csi (mode_reg == aekd_pkg::MODE_CSI),
        .len    (len_reg),
        .byte2  (byte2_reg),
        .byte3  (byte3_reg),
        .cur    (b),
        .match  (match)
    );

    always_comb
    begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        byte2_next = byte2_reg;
        byte3_next = byte3_reg;
        emit       = 1'b0;
        event_val  = '0;
        case (mode_reg)
            aekd_pkg::MODE_IDLE:
            begin
                if (b == aekd_pkg::BYTE_ESC)
                begin
                    mode_next = aekd_pkg::MODE_ESC;
                    len_next  = LW'(1);
                end
                else if (b >= aekd_pkg::BYTE_SPACE && b <= aekd_pkg::BYTE_TILDE)
                begin
                    emit                   = 1'b1;
                    event_val.is_printable = 1'b1;
                    event_val.char_code    = b[6:0];
                end
                else if (b == aekd_pkg::BYTE_LF || b == aekd_pkg::BYTE_CR)
                begin
                    emit                  = 1'b1;
                    event_val.special_key = aekd_pkg::KEY_ENTER;
                end
                else if (b == aekd_pkg::BYTE_BS || b == aekd_pkg::BYTE_DEL)
                begin
                    emit                  = 1'b1;
                    event_val.special_key = aekd_pkg::KEY_BACKSPACE;
                end
                else if (b == aekd_pkg::BYTE_TAB)
                begin
                    emit                  = 1'b1;
                    event_val.special_key = aekd_pkg::KEY_TAB;
                end
                else if (b == aekd_pkg::BYTE_ETX)
                begin
                    emit                  = 1'b1;
                    event_val.special_key = aekd_pkg::KEY_ESCAPE;
                end
            end
            aekd_pkg::MODE_ESC:
            begin
                if (b == aekd_pkg::BYTE_LBRK)
                begin
                    mode_next = aekd_pkg::MODE_CSI;
                    len_next  = LW'(2);
                end
                else if (b == aekd_pkg::BYTE_SS3)
                begin
                    mode_next = aekd_pkg::MODE_SS3;
                    len_next  = LW'(2);
                end
                else
                begin
                    mode_next             = aekd_pkg::MODE_IDLE;
                    len_next              = '0;
                    emit                  = 1'b1;
                    event_val.special_key = aekd_pkg::KEY_ESCAPE;
                end
            end
            default:
            begin
                if (len_reg >= LW'(aekd_pkg::MAX_SEQ_LEN))
                begin
                    mode_next = aekd_pkg::MODE_IDLE;
                    len_next  = '0;
                end
                else
                begin
                    // only the bytes a known sequence can hold are kept
                    if (len_reg == LW'(2))
                        byte2_next = b;
                    if (len_reg == LW'(3))
                        byte3_next = b;
                    len_next = len_inc;
                    if (is_final)
                    begin
                        mode_next             = aekd_pkg::MODE_IDLE;
                        len_next              = '0;
                        emit                  = match.hit;
                        event_val.special_key = match.key;
                    end
                    else if (len_inc >= LW'(aekd_pkg::MAX_SEQ_LEN - 1))
                    begin
                        mode_next = aekd_pkg::MODE_IDLE;
                        len_next  = '0;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !key.ready;
        out_next       = out_reg;
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
            out_next       = event_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= aekd_pkg::MODE_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte2_reg <= byte2_next;
            byte3_reg <= byte3_next;
        end
        out_reg <= out_next;
    end

    assign key.valid        = out_valid_reg;
    assign key.is_printable = out_reg.is_printable;
    assign key.char_code    = out_reg.char_code;
    assign key.special_key  = out_reg.special_key;

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == aekd_pkg::MODE_IDLE |-> len_reg == '0)
        else $error("idle parser holds buffered bytes");

    a_esc_len: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == aekd_pkg::MODE_ESC |-> len_reg == LW'(1))
        else $error("escape state with wrong length");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg < LW'(aekd_pkg::MAX_SEQ_LEN - 1))
        else $error("sequence length past abort limit");

    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        key.valid && key.is_printable |->
            key.char_code >= 7'd32 && key.char_code <= 7'd126 && key.special_key == '0)
        else $error("bad printable event");

    a_special: assert property (@(posedge clk) disable iff (!rst_n)
        key.valid && !key.is_printable |->
            key.char_code == '0 && key.special_key <= aekd_pkg::KEY_ESCAPE)
        else $error("bad special key event");

endmodule

// ----- bench/ansi_escape_key_decoder_tb.sv -----
`timescale 1ns / 1ps

module ansi_escape_key_decoder_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 125;

    typedef struct packed {
        logic [7:0]           b;
        logic                 typed;
        logic                 hit;
        aekd_pkg::key_event_t ev;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [26] = '{
        '{aekd_pkg::BYTE_SPACE, 1'b1, 1'b1, {1'b1, 7'd32, 5'd0}},
        '{aekd_pkg::BYTE_TILDE, 1'b1, 1'b1, {1'b1, 7'd126, 5'd0}},
        '{8'h00, 1'b1, 1'b0, 13'd0},
        '{8'h80, 1'b1, 1'b0, 13'd0},
        '{8'hFF, 1'b1, 1'b0, 13'd0},
        '{aekd_pkg::BYTE_CR, 1'b1, 1'b1, {1'b0, 7'd0, aekd_pkg::KEY_ENTER}},
        '{aekd_pkg::BYTE_LF, 1'b1, 1'b1, {1'b0, 7'd0, aekd_pkg::KEY_ENTER}},
        '{aekd_pkg::BYTE_BS, 1'b1, 1'b1, {1'b0, 7'd0, aekd_pkg::KEY_BACKSPACE}},
        '{aekd_pkg::BYTE_DEL, 1'b1, 1'b1, {1'b0, 7'd0, aekd_pkg::KEY_BACKSPACE}},
        '{aekd_pkg::BYTE_TAB, 1'b1, 1'b1, {1'b0, 7'd0, aekd_pkg::KEY_TAB}},
        '{aekd_pkg::BYTE_ETX, 1'b1, 1'b1, {1'b0, 7'd0, aekd_pkg::KEY_ESCAPE}},
        '{aekd_pkg::BYTE_ESC, 1'b1, 1'b0, 13'd0},
        '{8'h78, 1'b1, 1'b1, {1'b0, 7'd0, aekd_pkg::KEY_ESCAPE}},
        '{aekd_pkg::BYTE_ESC, 1'b1, 1'b0, 13'd0},
        '{aekd_pkg::BYTE_ESC, 1'b1, 1'b1, {1'b0, 7'd0, aekd_pkg::KEY_ESCAPE}},
        '{aekd_pkg::BYTE_ESC, 1'b0, 1'b0, 13'd0},
        '{aekd_pkg::BYTE_LBRK, 1'b0, 1'b0, 13'd0},
        '{aekd_pkg::BYTE_UC_A, 1'b0, 1'b0, 13'd0},
        '{aekd_pkg::BYTE_ESC, 1'b0, 1'b0, 13'd0},
        '{aekd_pkg::BYTE_SS3, 1'b0, 1'b0, 13'd0},
        '{8'h53, 1'b0, 1'b0, 13'd0},
        '{aekd_pkg::BYTE_ESC, 1'b0, 1'b0, 13'd0},
        '{aekd_pkg::BYTE_LBRK, 1'b0, 1'b0, 13'd0},
        '{8'h32, 1'b0, 1'b0, 13'd0},
        '{8'h34, 1'b0, 1'b0, 13'd0},
        '{aekd_pkg::BYTE_TILDE, 1'b0, 1'b0, 13'd0}
    };

    logic clk;
    logic rst_n;

    aekd_rx_if  rx_bus ();
    aekd_key_if key_bus ();

    ansi_escape_key_decoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_bus),
        .key   (key_bus)
    );

    aekd_pkg::mode_t dec_mode = aekd_pkg::MODE_IDLE;
    logic [7:0]      seq_buf [aekd_pkg::MAX_SEQ_LEN];
    int              seq_len = 0;

    aekd_pkg::key_event_t pending_keys [$];
    int         mismatches = 0;
    int         cycle_count = 0;
    int         decoded_bytes = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic string known_tail(input logic [4:0] k);
        case (k)
            aekd_pkg::KEY_UP:     return "[A";
            aekd_pkg::KEY_DOWN:   return "[B";
            aekd_pkg::KEY_RIGHT:  return "[C";
            aekd_pkg::KEY_LEFT:   return "[D";
            aekd_pkg::KEY_F1:     return "OP";
            aekd_pkg::KEY_F2:     return "OQ";
            aekd_pkg::KEY_F3:     return "OR";
            aekd_pkg::KEY_F4:     return "OS";
            aekd_pkg::KEY_F5:     return "[15~";
            aekd_pkg::KEY_F6:     return "[17~";
            aekd_pkg::KEY_F7:     return "[18~";
            aekd_pkg::KEY_F8:     return "[19~";
            aekd_pkg::KEY_F9:     return "[20~";
            aekd_pkg::KEY_F10:    return "[21~";
            aekd_pkg::KEY_F11:    return "[23~";
            aekd_pkg::KEY_F12:    return "[24~";
            aekd_pkg::KEY_HOME:   return "[1~";
            aekd_pkg::KEY_END:    return "[4~";
            aekd_pkg::KEY_PGUP:   return "[5~";
            aekd_pkg::KEY_PGDN:   return "[6~";
            aekd_pkg::KEY_INS:    return "[2~";
            aekd_pkg::KEY_DELETE: return "[3~";
            default:              return "";
        endcase
    endfunction

    function automatic aekd_pkg::key_event_t special(input logic [4:0] k);
        aekd_pkg::key_event_t ev;
        ev = '0;
        ev.special_key = k;
        return ev;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, output bit produced,
                                        output aekd_pkg::key_event_t ev);
        string      tail;
        bit         same;
        bit         found;
        logic [4:0] hit_key;
        produced = 1'b0;
        ev = '0;
        found = 1'b0;
        hit_key = aekd_pkg::KEY_UP;
        case (dec_mode)
            aekd_pkg::MODE_IDLE:
            begin
                if (b == aekd_pkg::BYTE_ESC)
                begin
                    dec_mode = aekd_pkg::MODE_ESC;
                    seq_buf[0] = b;
                    seq_len = 1;
                end
                else if (b >= aekd_pkg::BYTE_SPACE && b <= aekd_pkg::BYTE_TILDE)
                begin
                    produced = 1'b1;
                    ev.is_printable = 1'b1;
                    ev.char_code = b[6:0];
                end
                else if (b == aekd_pkg::BYTE_LF || b == aekd_pkg::BYTE_CR)
                begin
                    produced = 1'b1;
                    ev = special(aekd_pkg::KEY_ENTER);
                end
                else if (b == aekd_pkg::BYTE_BS || b == aekd_pkg::BYTE_DEL)
                begin
                    produced = 1'b1;
                    ev = special(aekd_pkg::KEY_BACKSPACE);
                end
                else if (b == aekd_pkg::BYTE_TAB)
                begin
                    produced = 1'b1;
                    ev = special(aekd_pkg::KEY_TAB);
                end
                else if (b == aekd_pkg::BYTE_ETX)
                begin
                    produced = 1'b1;
                    ev = special(aekd_pkg::KEY_ESCAPE);
                end
            end
            aekd_pkg::MODE_ESC:
            begin
                if (b == aekd_pkg::BYTE_LBRK || b == aekd_pkg::BYTE_SS3)
                begin
                    if (seq_len < aekd_pkg::MAX_SEQ_LEN)
                    begin
                        seq_buf[seq_len] = b;
                        seq_len++;
                    end
                    dec_mode = (b == aekd_pkg::BYTE_LBRK) ? aekd_pkg::MODE_CSI
                                                          : aekd_pkg::MODE_SS3;
                end
                else
                begin
                    dec_mode = aekd_pkg::MODE_IDLE;
                    seq_len = 0;
                    produced = 1'b1;
                    ev = special(aekd_pkg::KEY_ESCAPE);
                end
            end
            default:
            begin
                if (seq_len >= aekd_pkg::MAX_SEQ_LEN)
                begin
                    dec_mode = aekd_pkg::MODE_IDLE;
                    seq_len = 0;
                end
                else
                begin
                    seq_buf[seq_len] = b;
                    seq_len++;
                    if ((b >= aekd_pkg::BYTE_UC_A && b <= aekd_pkg::BYTE_UC_Z)
                        || b == aekd_pkg::BYTE_TILDE)
                    begin
                        for (int k = aekd_pkg::KEY_UP; k <= aekd_pkg::KEY_DELETE; k++)
                        begin
                            tail = known_tail(5'(k));
                            if (!found && seq_len == tail.len() + 1)
                            begin
                                same = 1'b1;
                                for (int j = 0; j < tail.len(); j++)
                                    if (seq_buf[j + 1] != tail[j])
                                        same = 1'b0;
                                if (same)
                                begin
                                    found = 1'b1;
                                    hit_key = 5'(k);
                                end
                            end
                        end
                        dec_mode = aekd_pkg::MODE_IDLE;
                        seq_len = 0;
                        if (found)
                        begin
                            produced = 1'b1;
                            ev = special(hit_key);
                        end
                    end
                    else if (seq_len >= aekd_pkg::MAX_SEQ_LEN - 1)
                    begin
                        dec_mode = aekd_pkg::MODE_IDLE;
                        seq_len = 0;
                    end
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input bit typed_hit = 1'b0,
                             input aekd_pkg::key_event_t typed_ev = '0);
        bit                   produced;
        bit                   was_idle;
        aekd_pkg::key_event_t ev;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            rx_bus.valid <= 1'b0;
            rx_bus.rx_byte <= 8'($urandom_range(0, 255));
            @(posedge clk);
        end
        rx_bus.valid <= 1'b1;
        rx_bus.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_bus.ready);
        was_idle = (dec_mode == aekd_pkg::MODE_IDLE);
        decode_byte(b, produced, ev);
        if (!(was_idle && !produced && b != aekd_pkg::BYTE_ESC))
            decoded_bytes++;
        if (typed)
        begin
            if (typed_hit)
                pending_keys.push_back(typed_ev);
        end
        else if (produced)
            pending_keys.push_back(ev);
    endtask

    task automatic send_chunk();
        int    kind;
        int    n;
        string tail;
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            tail = known_tail(5'($urandom_range(aekd_pkg::KEY_UP, aekd_pkg::KEY_DELETE)));
            send_byte(aekd_pkg::BYTE_ESC);
            for (int j = 0; j < tail.len(); j++)
                send_byte(tail[j]);
        end
        else if (kind < 55)
        begin
            // random sequence, mostly unknown or malformed
            send_byte(aekd_pkg::BYTE_ESC);
            send_byte($urandom_range(0, 1) ? aekd_pkg::BYTE_LBRK : aekd_pkg::BYTE_SS3);
            n = $urandom_range(0, 4);
            repeat (n)
                send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(48, 59)));
            send_byte(($urandom_range(0, 7) == 0)
                      ? aekd_pkg::BYTE_TILDE
                      : 8'($urandom_range(aekd_pkg::BYTE_UC_A, aekd_pkg::BYTE_UC_Z)));
        end
        else if (kind < 63)
        begin
            // around the overlong limit
            send_byte(aekd_pkg::BYTE_ESC);
            send_byte(aekd_pkg::BYTE_LBRK);
            n = $urandom_range(11, 15);
            repeat (n)
                send_byte(8'($urandom_range(48, 57)));
            if ($urandom_range(0, 1))
                send_byte(8'($urandom_range(aekd_pkg::BYTE_UC_A, aekd_pkg::BYTE_UC_Z)));
        end
        else if (kind < 70)
        begin
            send_byte(aekd_pkg::BYTE_ESC);
            send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                send_byte($urandom_range(0, 1)
                          ? 8'($urandom_range(aekd_pkg::BYTE_SPACE, aekd_pkg::BYTE_TILDE))
                          : 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        key_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            key_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        aekd_pkg::key_event_t want;
        if (rst_n && key_bus.valid && key_bus.ready)
        begin
            if (pending_keys.size() == 0)
                report_mismatch($sformatf("unexpected key event p=%0b c=%0d k=%0d",
                                key_bus.is_printable, key_bus.char_code,
                                key_bus.special_key));
            else
            begin
                want = pending_keys.pop_front();
                if (key_bus.is_printable !== want.is_printable)
                    report_mismatch($sformatf("is_printable %0b, wanted %0b",
                                    key_bus.is_printable, want.is_printable));
                if (key_bus.char_code !== want.char_code)
                    report_mismatch($sformatf("char_code %0d, wanted %0d",
                                    key_bus.char_code, want.char_code));
                if (key_bus.special_key !== want.special_key)
                    report_mismatch($sformatf("special_key %0d, wanted %0d",
                                    key_bus.special_key, want.special_key));
            end
        end
    end

    initial
    begin
        int target;
        rst_n = 1'b0;
        rx_bus.valid = 1'b0;
        rx_bus.rx_byte = 8'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].hit,
                      DIRECTED_ROWS[i].ev);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 58; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            target = decoded_bytes + PHASE_ITEMS;
            while (decoded_bytes < target)
                send_chunk();
        end

        rx_bus.valid <= 1'b0;
        while (pending_keys.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
